### design/ips_pkg.sv
// ----------------------------------------------------------------------------
// ips_pkg
// Shared types, constants and helpers for the intercept point solver.
// ----------------------------------------------------------------------------
package ips_pkg;

  localparam int COORD_BITS = 16;

  // divider: numerator, divisor, quotient and remainder widths
  localparam int DIV_NW  = 52;
  localparam int DIV_DW  = 36;
  localparam int DIV_QW  = 20;
  localparam int DIV_RW  = DIV_DW + DIV_QW;
  localparam int DIV_LAT = DIV_QW + 1;

  // square root: radicand width, working width, result bits
  localparam int SQ_W     = 34;
  localparam int SQ_RW    = 35;
  localparam int SQ_STEPS = 17;
  localparam int SQ_LAT   = SQ_STEPS + 1;

  localparam logic [2:0] CODE_STILL   = 3'd0;
  localparam logic [2:0] CODE_PROJ    = 3'd1;
  localparam logic [2:0] CODE_INSIDE  = 3'd2;
  localparam logic [2:0] CODE_CLAMP_A = 3'd3;
  localparam logic [2:0] CODE_CLAMP_B = 3'd4;
  localparam logic [2:0] CODE_PAR     = 3'd5;
  localparam logic [2:0] CODE_ZERO    = 3'd6;

  localparam logic [2:0] REG_SEG_A_X   = 3'd0;
  localparam logic [2:0] REG_SEG_A_Y   = 3'd1;
  localparam logic [2:0] REG_SEG_B_X   = 3'd2;
  localparam logic [2:0] REG_SEG_B_Y   = 3'd3;
  localparam logic [2:0] REG_SEG_VALID = 3'd4;
  localparam logic [2:0] REG_SPIN_EN   = 3'd5;
  localparam logic [2:0] REG_ARRIVE    = 3'd6;
  localparam logic [2:0] REG_MIN_SPEED = 3'd7;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    coord_t      seg_a_x;
    coord_t      seg_a_y;
    coord_t      seg_b_x;
    coord_t      seg_b_y;
    logic        seg_valid;
    logic        spin_enable;
    logic [14:0] arrive_tolerance;
    logic [14:0] min_speed;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  code;
    logic        neg_x;
    logic        neg_y;
    coord_t      off_x;
    coord_t      off_y;
    coord_t      fix_x;
    coord_t      fix_y;
    coord_t      ox;
    coord_t      oy;
    coord_t      px;
    coord_t      py;
    logic [31:0] s2;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [DIV_NW-1:0] n_x;
    logic [DIV_NW-1:0] n_y;
    logic [DIV_DW-1:0] d;
  } front_t;

  // offset plus signed rounded quotient, saturated to a coordinate
  function automatic coord_t sat_q(input coord_t off, input logic neg,
                                   input logic [DIV_QW-1:0] q, input logic ovf);
    logic signed [DIV_QW+1:0] qs;
    logic signed [DIV_QW+1:0] v;
    coord_t                   res;
    qs = $signed({2'b00, q});
    if (neg) qs = -qs;
    v = qs + (DIV_QW+2)'(off);
    if (ovf) res = neg ? COORD_MIN : COORD_MAX;
    else if (v > (DIV_QW+2)'(COORD_MAX)) res = COORD_MAX;
    else if (v < (DIV_QW+2)'(COORD_MIN)) res = COORD_MIN;
    else res = v[COORD_BITS-1:0];
    return res;
  endfunction

endpackage

### design/ips_div.sv
// ----------------------------------------------------------------------------
// ips_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module ips_div (
  input  logic                           clk,
  input  logic [ips_pkg::DIV_NW-1:0]     num,
  input  logic [ips_pkg::DIV_DW-1:0]     den,
  output logic [ips_pkg::DIV_QW-1:0]     quo,
  output logic                           ovf
);

  logic [ips_pkg::DIV_RW-1:0] rem_p [ips_pkg::DIV_QW];
  logic [ips_pkg::DIV_DW-1:0] den_p [ips_pkg::DIV_QW];
  logic [ips_pkg::DIV_QW-1:0] q_p   [ips_pkg::DIV_QW+1];
  logic                       ovf_p [ips_pkg::DIV_QW+1];

  always_ff @(posedge clk) begin
    rem_p[0] <= ips_pkg::DIV_RW'(num);
    den_p[0] <= den;
    q_p[0]   <= '0;
    // quotient would not fit in the quotient bits
    ovf_p[0] <= (ips_pkg::DIV_RW'(num) >=
                 (ips_pkg::DIV_RW'(den) << ips_pkg::DIV_QW));
  end

  for (genvar k = 1; k <= ips_pkg::DIV_QW; k++) begin : g_step
    logic [ips_pkg::DIV_RW-1:0] sub;
    logic                       fits;
    assign sub  = ips_pkg::DIV_RW'(den_p[k-1]) << (ips_pkg::DIV_QW - k);
    assign fits = (rem_p[k-1] >= sub);

    always_ff @(posedge clk) begin
      q_p[k]   <= {q_p[k-1][ips_pkg::DIV_QW-2:0], fits};
      ovf_p[k] <= ovf_p[k-1];
    end

    if (k < ips_pkg::DIV_QW) begin : g_rem
      always_ff @(posedge clk) begin
        rem_p[k] <= fits ? (rem_p[k-1] - sub) : rem_p[k-1];
        den_p[k] <= den_p[k-1];
      end
    end
  end

  assign quo = q_p[ips_pkg::DIV_QW];
  assign ovf = ovf_p[ips_pkg::DIV_QW];

endmodule

### design/ips_sqrt.sv
// ----------------------------------------------------------------------------
// ips_sqrt
// Pipelined integer square root (floor), one result bit per stage.
// ----------------------------------------------------------------------------
module ips_sqrt (
  input  logic                          clk,
  input  logic [ips_pkg::SQ_W-1:0]      radicand,
  output logic [ips_pkg::SQ_STEPS-1:0]  root
);

  logic [ips_pkg::SQ_RW-1:0] x_p [ips_pkg::SQ_STEPS];
  logic [ips_pkg::SQ_RW-1:0] r_p [ips_pkg::SQ_STEPS+1];

  always_ff @(posedge clk) begin
    x_p[0] <= ips_pkg::SQ_RW'(radicand);
    r_p[0] <= '0;
  end

  for (genvar k = 1; k <= ips_pkg::SQ_STEPS; k++) begin : g_step
    logic [ips_pkg::SQ_RW-1:0] bitv;
    logic [ips_pkg::SQ_RW-1:0] trial;
    logic                      fits;
    assign bitv  = ips_pkg::SQ_RW'(1) << (2 * (ips_pkg::SQ_STEPS - k));
    assign trial = r_p[k-1] + bitv;
    assign fits  = (x_p[k-1] >= trial);

    always_ff @(posedge clk) begin
      r_p[k] <= fits ? ((r_p[k-1] >> 1) + bitv) : (r_p[k-1] >> 1);
    end

    if (k < ips_pkg::SQ_STEPS) begin : g_rem
      always_ff @(posedge clk) begin
        x_p[k] <= fits ? (x_p[k-1] - trial) : x_p[k-1];
      end
    end
  end

  assign root = r_p[ips_pkg::SQ_STEPS][ips_pkg::SQ_STEPS-1:0];

endmodule

### design/ips_front.sv
// ----------------------------------------------------------------------------
// ips_front
// Front pipeline: still test, projection or segment crossing setup, case
// decision and the divider operands for the target.
// ----------------------------------------------------------------------------
module ips_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  ips_pkg::coord_t ox,
  input  ips_pkg::coord_t oy,
  input  ips_pkg::coord_t vx,
  input  ips_pkg::coord_t vy,
  input  ips_pkg::coord_t px,
  input  ips_pkg::coord_t py,
  input  ips_pkg::cfg_t   cfg,
  output ips_pkg::front_t fo
);

  typedef struct packed {
    logic               valid;
    ips_pkg::coord_t    ox, oy, vx, vy, px, py;
    logic signed [16:0] wdx, wdy, qx, qy, dx, dy;
    logic [30:0]        sqx, sqy;
  } s1_t;

  typedef struct packed {
    logic               valid;
    ips_pkg::coord_t    ox, oy, vx, vy, px, py;
    logic signed [16:0] dx, dy;
    logic signed [32:0] wpx, wpy, dvy, dyvx, n1, n2;
    logic [31:0]        s2;
  } s2_t;

  typedef struct packed {
    logic               valid;
    ips_pkg::coord_t    ox, oy, vx, vy, px, py;
    logic signed [16:0] dx, dy;
    logic signed [33:0] wv, den, num;
    logic [31:0]        s2;
    logic               still;
  } s3_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         code;
    logic signed [33:0] a;
    logic signed [16:0] bx, by;
    logic [33:0]        d;
    ips_pkg::coord_t    off_x, off_y, fix_x, fix_y, ox, oy, px, py;
    logic [31:0]        s2;
  } s4_t;

  typedef struct packed {
    ips_pkg::side_t     side;
    logic signed [50:0] prx, pry;
    logic [33:0]        d;
  } s5_t;

  s1_t s1, s1_next;
  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s4_t s4, s4_next;
  s5_t s5, s5_next;
  ips_pkg::front_t fo_next;

  // stage 1: differences and speed squares
  always_comb begin
    logic signed [31:0] sqx_w, sqy_w;
    sqx_w = vx * vx;
    sqy_w = vy * vy;
    s1_next.valid = in_valid;
    s1_next.ox = ox;
    s1_next.oy = oy;
    s1_next.vx = vx;
    s1_next.vy = vy;
    s1_next.px = px;
    s1_next.py = py;
    s1_next.wdx = 17'(px) - 17'(ox);
    s1_next.wdy = 17'(py) - 17'(oy);
    s1_next.qx  = 17'(ox) - 17'(cfg.seg_a_x);
    s1_next.qy  = 17'(oy) - 17'(cfg.seg_a_y);
    s1_next.dx  = 17'(cfg.seg_b_x) - 17'(cfg.seg_a_x);
    s1_next.dy  = 17'(cfg.seg_b_y) - 17'(cfg.seg_a_y);
    s1_next.sqx = sqx_w[30:0];
    s1_next.sqy = sqy_w[30:0];
  end

  // stage 2: products for dot and cross terms
  always_comb begin
    s2_next.valid = s1.valid;
    s2_next.ox = s1.ox;
    s2_next.oy = s1.oy;
    s2_next.vx = s1.vx;
    s2_next.vy = s1.vy;
    s2_next.px = s1.px;
    s2_next.py = s1.py;
    s2_next.dx = s1.dx;
    s2_next.dy = s1.dy;
    s2_next.wpx  = s1.wdx * s1.vx;
    s2_next.wpy  = s1.wdy * s1.vy;
    s2_next.dvy  = s1.dx * s1.vy;
    s2_next.dyvx = s1.dy * s1.vx;
    s2_next.n1   = s1.qx * s1.vy;
    s2_next.n2   = s1.qy * s1.vx;
    s2_next.s2   = 32'(s1.sqx) + 32'(s1.sqy);
  end

  // stage 3: sums and still test
  always_comb begin
    logic [29:0] ms2;
    ms2 = 30'(cfg.min_speed) * 30'(cfg.min_speed);
    s3_next.valid = s2.valid;
    s3_next.ox = s2.ox;
    s3_next.oy = s2.oy;
    s3_next.vx = s2.vx;
    s3_next.vy = s2.vy;
    s3_next.px = s2.px;
    s3_next.py = s2.py;
    s3_next.dx = s2.dx;
    s3_next.dy = s2.dy;
    s3_next.wv  = 34'(s2.wpx) + 34'(s2.wpy);
    s3_next.den = 34'(s2.dvy) - 34'(s2.dyvx);
    s3_next.num = 34'(s2.n1) - 34'(s2.n2);
    s3_next.s2  = s2.s2;
    s3_next.still = (s2.s2 <= 32'(ms2));
  end

  // stage 4: case decision and multiplier operands
  always_comb begin
    logic signed [33:0] den_c, num_c;
    den_c = s3.den;
    num_c = s3.num;
    if (s3.den[33]) begin
      den_c = -s3.den;
      num_c = -s3.num;
    end
    s4_next.valid = s3.valid;
    s4_next.code  = ips_pkg::CODE_PAR;
    s4_next.a     = '0;
    s4_next.bx    = '0;
    s4_next.by    = '0;
    s4_next.d     = 34'(s3.s2);
    s4_next.off_x = s3.ox;
    s4_next.off_y = s3.oy;
    s4_next.fix_x = s3.px;
    s4_next.fix_y = s3.py;
    s4_next.ox    = s3.ox;
    s4_next.oy    = s3.oy;
    s4_next.px    = s3.px;
    s4_next.py    = s3.py;
    s4_next.s2    = s3.s2;
    if (s3.still) begin
      s4_next.code = ips_pkg::CODE_STILL;
    end else if (!cfg.seg_valid) begin
      s4_next.code = ips_pkg::CODE_PROJ;
      s4_next.a    = s3.wv;
      s4_next.bx   = 17'(s3.vx);
      s4_next.by   = 17'(s3.vy);
    end else if (s3.den == '0) begin
      s4_next.code = ips_pkg::CODE_PAR;
    end else if (num_c[33]) begin
      s4_next.code  = ips_pkg::CODE_CLAMP_A;
      s4_next.fix_x = cfg.seg_a_x;
      s4_next.fix_y = cfg.seg_a_y;
    end else if (num_c > den_c) begin
      s4_next.code  = ips_pkg::CODE_CLAMP_B;
      s4_next.fix_x = cfg.seg_b_x;
      s4_next.fix_y = cfg.seg_b_y;
    end else begin
      s4_next.code  = ips_pkg::CODE_INSIDE;
      s4_next.a     = num_c;
      s4_next.bx    = s3.dx;
      s4_next.by    = s3.dy;
      s4_next.d     = $unsigned(den_c);
      s4_next.off_x = cfg.seg_a_x;
      s4_next.off_y = cfg.seg_a_y;
    end
  end

  // stage 5: numerator products
  always_comb begin
    s5_next.side.valid = s4.valid;
    s5_next.side.code  = s4.code;
    s5_next.side.neg_x = 1'b0;
    s5_next.side.neg_y = 1'b0;
    s5_next.side.off_x = s4.off_x;
    s5_next.side.off_y = s4.off_y;
    s5_next.side.fix_x = s4.fix_x;
    s5_next.side.fix_y = s4.fix_y;
    s5_next.side.ox    = s4.ox;
    s5_next.side.oy    = s4.oy;
    s5_next.side.px    = s4.px;
    s5_next.side.py    = s4.py;
    s5_next.side.s2    = s4.s2;
    s5_next.prx = s4.a * s4.bx;
    s5_next.pry = s4.a * s4.by;
    s5_next.d   = s4.d;
  end

  // stage 6: round-to-nearest operands, 2|n|+d over 2d
  always_comb begin
    logic signed [50:0] mag_x, mag_y;
    mag_x = s5.prx[50] ? -s5.prx : s5.prx;
    mag_y = s5.pry[50] ? -s5.pry : s5.pry;
    fo_next.side       = s5.side;
    fo_next.side.neg_x = s5.prx[50];
    fo_next.side.neg_y = s5.pry[50];
    fo_next.n_x = (ips_pkg::DIV_NW'($unsigned(mag_x)) << 1) + ips_pkg::DIV_NW'(s5.d);
    fo_next.n_y = (ips_pkg::DIV_NW'($unsigned(mag_y)) << 1) + ips_pkg::DIV_NW'(s5.d);
    fo_next.d   = ips_pkg::DIV_DW'({s5.d, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
      s4.valid <= 1'b0;
      s5.side.valid <= 1'b0;
      fo.side.valid <= 1'b0;
    end else begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
      s5 <= s5_next;
      fo <= fo_next;
    end
  end

endmodule

### design/intercept_point_solver_top.sv
// ----------------------------------------------------------------------------
// intercept_point_solver_top
// Intercept target, drive velocity and spin select for a moving object.
// ----------------------------------------------------------------------------
// Usage:
//   An item (object position and velocity, player position) is taken at a
//   rising edge with start high and busy low. busy stays low: the block is a
//   fully pipelined datapath and takes one item every clock.
//   Each result is shown on the result ports for one cycle with done high,
//   in item order. The receiver cannot stall, so results are never held.
//   The pipeline: setup and products (6 stages), a 21-stage divider for the
//   target, 4 stages of distance math, an 18-stage square root for speed and
//   object distance, 2 stages of drive products, a second 21-stage divider
//   for the drive velocity, then the output register.
//   Configuration is written through wr_en / wr_index / wr_data while no
//   item is in flight.
//   rst (synchronous) clears all valid bits in flight and loads the
//   register defaults; items in flight at reset are dropped.
// ----------------------------------------------------------------------------
module intercept_point_solver_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ips_pkg::coord_t obj_x,
  input  ips_pkg::coord_t obj_y,
  input  ips_pkg::coord_t obj_vx,
  input  ips_pkg::coord_t obj_vy,
  input  ips_pkg::coord_t player_x,
  input  ips_pkg::coord_t player_y,
  input  logic            wr_en,
  input  logic [2:0]      wr_index,
  input  logic [15:0]     wr_data,
  output logic            done,
  output ips_pkg::coord_t target_x,
  output ips_pkg::coord_t target_y,
  output ips_pkg::coord_t drive_vx,
  output ips_pkg::coord_t drive_vy,
  output logic            spin_select,
  output logic [2:0]      case_code
);

  typedef struct packed {
    logic            valid;
    logic [2:0]      code;
    ips_pkg::coord_t tx, ty, ox, oy, px, py;
    logic [31:0]     s2;
  } t1_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         code;
    ips_pkg::coord_t    tx, ty;
    logic signed [16:0] ddx, ddy, odx, ody;
    logic [31:0]        s2;
  } t2_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         code;
    ips_pkg::coord_t    tx, ty;
    logic signed [16:0] ddx, ddy;
    logic [31:0]        ddx2, ddy2, odx2, ody2;
    logic [31:0]        s2;
  } t3_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         code;
    ips_pkg::coord_t    tx, ty;
    logic signed [16:0] ddx, ddy;
    logic               spin;
  } t4_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         code;
    ips_pkg::coord_t    tx, ty;
    logic               spin;
    logic signed [34:0] prx, pry;
    logic [16:0]        od;
  } t5_t;

  typedef struct packed {
    logic            valid;
    logic [2:0]      code;
    ips_pkg::coord_t tx, ty;
    logic            spin;
    logic            neg_x, neg_y;
  } t6_t;

  ips_pkg::cfg_t   cfg;
  ips_pkg::front_t fo;

  logic [ips_pkg::DIV_QW-1:0] qt_x, qt_y, qd_x, qd_y;
  logic                       ot_x, ot_y, od_x, od_y;
  logic [ips_pkg::SQ_STEPS-1:0] root_od, root_s;

  ips_pkg::side_t sa_d [ips_pkg::DIV_LAT];
  t1_t t1, t1_next;
  t2_t t2, t2_next;
  t3_t t3, t3_next;
  t4_t t4, t4_next;
  logic [32:0] od2, od2_next;
  logic [31:0] s2q;
  t4_t sq_d [ips_pkg::SQ_LAT];
  t5_t t5, t5_next;
  t6_t t6, t6_next;
  logic [ips_pkg::DIV_NW-1:0] dn_x, dn_y, dn_x_next, dn_y_next;
  logic [ips_pkg::DIV_DW-1:0] dd, dd_next;
  t6_t dv_d [ips_pkg::DIV_LAT];

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seg_a_x          <= '0;
      cfg.seg_a_y          <= '0;
      cfg.seg_b_x          <= '0;
      cfg.seg_b_y          <= '0;
      cfg.seg_valid        <= 1'b0;
      cfg.spin_enable      <= 1'b0;
      cfg.arrive_tolerance <= 15'd205;
      cfg.min_speed        <= 15'd41;
    end else if (wr_en) begin
      unique case (wr_index)
        ips_pkg::REG_SEG_A_X:   cfg.seg_a_x          <= wr_data;
        ips_pkg::REG_SEG_A_Y:   cfg.seg_a_y          <= wr_data;
        ips_pkg::REG_SEG_B_X:   cfg.seg_b_x          <= wr_data;
        ips_pkg::REG_SEG_B_Y:   cfg.seg_b_y          <= wr_data;
        ips_pkg::REG_SEG_VALID: cfg.seg_valid        <= wr_data[0];
        ips_pkg::REG_SPIN_EN:   cfg.spin_enable      <= wr_data[0];
        ips_pkg::REG_ARRIVE:    cfg.arrive_tolerance <= wr_data[14:0];
        ips_pkg::REG_MIN_SPEED: cfg.min_speed        <= wr_data[14:0];
        default: ;
      endcase
    end
  end

  ips_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .ox       (obj_x),
    .oy       (obj_y),
    .vx       (obj_vx),
    .vy       (obj_vy),
    .px       (player_x),
    .py       (player_y),
    .cfg      (cfg),
    .fo       (fo)
  );

  ips_div u_div_tx (.clk(clk), .num(fo.n_x), .den(fo.d), .quo(qt_x), .ovf(ot_x));
  ips_div u_div_ty (.clk(clk), .num(fo.n_y), .den(fo.d), .quo(qt_y), .ovf(ot_y));

  // target: divided result or a fixed point chosen up front
  always_comb begin
    ips_pkg::side_t s;
    s = sa_d[ips_pkg::DIV_LAT-1];
    t1_next.valid = s.valid;
    t1_next.code  = s.code;
    t1_next.ox    = s.ox;
    t1_next.oy    = s.oy;
    t1_next.px    = s.px;
    t1_next.py    = s.py;
    t1_next.s2    = s.s2;
    if (s.code == ips_pkg::CODE_PROJ || s.code == ips_pkg::CODE_INSIDE) begin
      t1_next.tx = ips_pkg::sat_q(s.off_x, s.neg_x, qt_x, ot_x);
      t1_next.ty = ips_pkg::sat_q(s.off_y, s.neg_y, qt_y, ot_y);
    end else begin
      t1_next.tx = s.fix_x;
      t1_next.ty = s.fix_y;
    end
  end

  // distances to player and object, zero-distance case
  always_comb begin
    t2_next.valid = t1.valid;
    t2_next.tx    = t1.tx;
    t2_next.ty    = t1.ty;
    t2_next.s2    = t1.s2;
    t2_next.ddx   = 17'(t1.tx) - 17'(t1.px);
    t2_next.ddy   = 17'(t1.ty) - 17'(t1.py);
    t2_next.odx   = 17'(t1.ox) - 17'(t1.tx);
    t2_next.ody   = 17'(t1.oy) - 17'(t1.ty);
    t2_next.code  = t1.code;
    if (t1.code != ips_pkg::CODE_STILL && t1.code != ips_pkg::CODE_PAR &&
        ((t2_next.ddx == '0 && t2_next.ddy == '0) ||
         (t2_next.odx == '0 && t2_next.ody == '0))) begin
      t2_next.code = ips_pkg::CODE_ZERO;
    end
  end

  always_comb begin
    logic signed [33:0] m_ddx, m_ddy, m_odx, m_ody;
    m_ddx = t2.ddx * t2.ddx;
    m_ddy = t2.ddy * t2.ddy;
    m_odx = t2.odx * t2.odx;
    m_ody = t2.ody * t2.ody;
    t3_next.valid = t2.valid;
    t3_next.code  = t2.code;
    t3_next.tx    = t2.tx;
    t3_next.ty    = t2.ty;
    t3_next.ddx   = t2.ddx;
    t3_next.ddy   = t2.ddy;
    t3_next.ddx2  = m_ddx[31:0];
    t3_next.ddy2  = m_ddy[31:0];
    t3_next.odx2  = m_odx[31:0];
    t3_next.ody2  = m_ody[31:0];
    t3_next.s2    = t2.s2;
  end

  // arrival test and radicand for the object distance
  always_comb begin
    logic [32:0] dp2;
    logic [29:0] tol2;
    dp2  = 33'(t3.ddx2) + 33'(t3.ddy2);
    tol2 = 30'(cfg.arrive_tolerance) * 30'(cfg.arrive_tolerance);
    t4_next.valid = t3.valid;
    t4_next.code  = t3.code;
    t4_next.tx    = t3.tx;
    t4_next.ty    = t3.ty;
    t4_next.ddx   = t3.ddx;
    t4_next.ddy   = t3.ddy;
    t4_next.spin  = cfg.spin_enable && (dp2 < 33'(tol2));
    od2_next      = 33'(t3.odx2) + 33'(t3.ody2);
  end

  ips_sqrt u_sqrt_od (.clk(clk), .radicand(ips_pkg::SQ_W'(od2)), .root(root_od));
  ips_sqrt u_sqrt_sp (.clk(clk), .radicand(ips_pkg::SQ_W'(s2q)), .root(root_s));

  // drive numerators: distance to player times object speed
  always_comb begin
    t4_t s;
    s = sq_d[ips_pkg::SQ_LAT-1];
    t5_next.valid = s.valid;
    t5_next.code  = s.code;
    t5_next.tx    = s.tx;
    t5_next.ty    = s.ty;
    t5_next.spin  = s.spin;
    t5_next.prx   = s.ddx * $signed({1'b0, root_s});
    t5_next.pry   = s.ddy * $signed({1'b0, root_s});
    t5_next.od    = root_od;
  end

  always_comb begin
    logic signed [34:0] mag_x, mag_y;
    mag_x = t5.prx[34] ? -t5.prx : t5.prx;
    mag_y = t5.pry[34] ? -t5.pry : t5.pry;
    t6_next.valid = t5.valid;
    t6_next.code  = t5.code;
    t6_next.tx    = t5.tx;
    t6_next.ty    = t5.ty;
    t6_next.spin  = t5.spin;
    t6_next.neg_x = t5.prx[34];
    t6_next.neg_y = t5.pry[34];
    dn_x_next = (ips_pkg::DIV_NW'($unsigned(mag_x)) << 1) + ips_pkg::DIV_NW'(t5.od);
    dn_y_next = (ips_pkg::DIV_NW'($unsigned(mag_y)) << 1) + ips_pkg::DIV_NW'(t5.od);
    dd_next   = ips_pkg::DIV_DW'({t5.od, 1'b0});
  end

  ips_div u_div_dx (.clk(clk), .num(dn_x), .den(dd), .quo(qd_x), .ovf(od_x));
  ips_div u_div_dy (.clk(clk), .num(dn_y), .den(dd), .quo(qd_y), .ovf(od_y));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ips_pkg::DIV_LAT; k++) sa_d[k].valid <= 1'b0;
      for (int k = 0; k < ips_pkg::SQ_LAT; k++) sq_d[k].valid <= 1'b0;
      for (int k = 0; k < ips_pkg::DIV_LAT; k++) dv_d[k].valid <= 1'b0;
      t1.valid <= 1'b0;
      t2.valid <= 1'b0;
      t3.valid <= 1'b0;
      t4.valid <= 1'b0;
      t5.valid <= 1'b0;
      t6.valid <= 1'b0;
    end else begin
      sa_d[0] <= fo.side;
      for (int k = 1; k < ips_pkg::DIV_LAT; k++) sa_d[k] <= sa_d[k-1];
      t1  <= t1_next;
      t2  <= t2_next;
      t3  <= t3_next;
      t4  <= t4_next;
      od2 <= od2_next;
      s2q <= t3.s2;
      sq_d[0] <= t4;
      for (int k = 1; k < ips_pkg::SQ_LAT; k++) sq_d[k] <= sq_d[k-1];
      t5   <= t5_next;
      t6   <= t6_next;
      dn_x <= dn_x_next;
      dn_y <= dn_y_next;
      dd   <= dd_next;
      dv_d[0] <= t6;
      for (int k = 1; k < ips_pkg::DIV_LAT; k++) dv_d[k] <= dv_d[k-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    t6_t s;
    s = dv_d[ips_pkg::DIV_LAT-1];
    target_x    <= s.tx;
    target_y    <= s.ty;
    spin_select <= s.spin;
    case_code   <= s.code;
    if (s.code == ips_pkg::CODE_PROJ || s.code == ips_pkg::CODE_INSIDE ||
        s.code == ips_pkg::CODE_CLAMP_A || s.code == ips_pkg::CODE_CLAMP_B) begin
      drive_vx <= ips_pkg::sat_q('0, s.neg_x, qd_x, od_x);
      drive_vy <= ips_pkg::sat_q('0, s.neg_y, qd_y, od_y);
    end else begin
      drive_vx <= '0;
      drive_vy <= '0;
    end
    if (rst) done <= 1'b0;
    else done <= s.valid;
  end

endmodule
